// ===== hw/rtl/bbc_pkg.sv =====
// Package with shared constants and types for the buffer cache block.
`timescale 1ns / 1ps
`default_nettype none
package bbc_pkg;
  localparam int NumBuffers = 32;
  localparam int SlotW = 5;
  localparam int RankW = $clog2(NumBuffers);

  localparam logic [1:0] ModeGet = 2'd0;
  localparam logic [1:0] ModeRelease = 2'd1;
  localparam logic [1:0] ModeFlags = 2'd2;

  localparam logic [2:0] StatusDone = 3'd0;
  localparam logic [2:0] StatusRecycled = 3'd1;
  localparam logic [2:0] StatusNoFree = 3'd2;
  localparam logic [2:0] StatusBadRelease = 3'd3;
  localparam logic [2:0] StatusOverflow = 3'd4;

  typedef enum logic [2:0] {
    StIdle,
    StMul,
    StScan,
    StApply,
    StOut
  } state_e;

  // Token carried down the row of cells during a scan.
  typedef struct packed {
    logic             hit;
    logic [SlotW-1:0] hit_slot;
    logic             free;
    logic [SlotW-1:0] free_slot;
    logic [RankW-1:0] free_rank;
  } scan_t;

  // Command broadcast to all cells.
  typedef struct packed {
    logic             recycle;
    logic             hit_inc;
    logic             rel_dec;
    logic             to_mru;
    logic             set_flags;
    logic [SlotW-1:0] slot;
    logic [RankW-1:0] rank;
    logic [7:0]       device;
    logic [31:0]      sector;
    logic             valid;
    logic             dirty;
  } cmd_t;
endpackage
`default_nettype wire

// ===== hw/rtl/bbc_cell.sv =====
// One cache entry: tag, flags, count and rank, with its stage of the scan chain.
`timescale 1ns / 1ps
`default_nettype none
module bbc_cell
  import bbc_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [SlotW-1:0] idx_i,
  input  wire logic [RankW-1:0] rank_rst_i,
  input  wire logic [7:0]       device_i,
  input  wire logic [31:0]      sector_i,
  input  wire scan_t            scan_i,
  output scan_t                 scan_o,
  input  wire cmd_t             cmd_i,
  output logic                  valid_o,
  output logic [7:0]            refs_o,
  output logic [RankW-1:0]      rank_o
);
  logic [7:0] dev_q, dev_d;
  logic [31:0] sec_q, sec_d;
  logic [7:0] refs_q, refs_d;
  logic valid_q, valid_d, dirty_q, dirty_d, used_q, used_d;
  logic [RankW-1:0] rank_q, rank_d;
  logic me, match, avail;

  assign me = (cmd_i.slot == idx_i);
  assign match = used_q && dev_q == device_i && sec_q == sector_i;
  assign avail = refs_q == 8'd0 && !dirty_q;

  // The first hit in slot order wins; among free entries the highest rank.
  always_comb begin
    scan_o = scan_i;
    if (match && !scan_i.hit) begin
      scan_o.hit = 1'b1;
      scan_o.hit_slot = idx_i;
    end
    if (avail && (!scan_i.free || rank_q > scan_i.free_rank)) begin
      scan_o.free = 1'b1;
      scan_o.free_slot = idx_i;
      scan_o.free_rank = rank_q;
    end
  end

  always_comb begin
    dev_d = dev_q;
    sec_d = sec_q;
    refs_d = refs_q;
    valid_d = valid_q;
    dirty_d = dirty_q;
    used_d = used_q;
    rank_d = rank_q;
    if (me && cmd_i.recycle) begin
      dev_d = cmd_i.device;
      sec_d = cmd_i.sector;
      valid_d = 1'b0;
      dirty_d = 1'b0;
      used_d = 1'b1;
      refs_d = 8'd1;
    end
    if (me && cmd_i.hit_inc) refs_d = refs_q + 8'd1;
    if (me && cmd_i.rel_dec) refs_d = refs_q - 8'd1;
    if (me && cmd_i.set_flags) begin
      valid_d = cmd_i.valid;
      dirty_d = cmd_i.dirty;
    end
    if (cmd_i.to_mru) begin
      if (me) rank_d = '0;
      else if (rank_q < cmd_i.rank) rank_d = rank_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_q <= '0;
      sec_q <= '0;
      refs_q <= '0;
      valid_q <= 1'b0;
      dirty_q <= 1'b0;
      used_q <= 1'b0;
      rank_q <= rank_rst_i;
    end else begin
      dev_q <= dev_d;
      sec_q <= sec_d;
      refs_q <= refs_d;
      valid_q <= valid_d;
      dirty_q <= dirty_d;
      used_q <= used_d;
      rank_q <= rank_d;
    end
  end

  assign valid_o = valid_q;
  assign refs_o = refs_q;
  assign rank_o = rank_q;
endmodule
`default_nettype wire

// ===== hw/rtl/block_buffer_cache_lru.sv =====
// Top level of the buffer cache tag and replacement manager.
`timescale 1ns / 1ps
`default_nettype none
// Buffer cache tag manager with LRU replacement over 32 entries held in a row of cells.
// A get runs through the tag multiply, then a scan in which a token walks the row of
// cells one registered stage per cycle (a stage register behind each entry, then a
// register that captures the verdict), then an apply step that loads the result register.
// A release, a flag update and the unused mode skip the scan and go from the multiply
// straight to the apply step. One item is in flight at a time; the result register holds
// the result until it is taken, and the input is ready again once the valid flag has
// cleared and the state machine has returned to idle.
module block_buffer_cache_lru
  import bbc_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [4:0]       cfg_wdata_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [1:0]       mode_i,
  input  wire logic [7:0]       device_i,
  input  wire logic [31:0]      block_in_fs_i,
  input  wire logic [31:0]      partition_base_i,
  input  wire logic [4:0]       slot_i,
  input  wire logic             valid_in_i,
  input  wire logic             dirty_in_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [4:0]            slot_out_o,
  output logic [2:0]            status_o,
  output logic                  data_valid_o,
  output logic [7:0]            ref_count_o
);
  logic [4:0] spb_q;
  state_e state_q, state_d;
  logic [1:0] mode_q;
  logic [7:0] dev_q;
  logic [31:0] blk_q, base_q, tag_q;
  logic [SlotW-1:0] slot_q;
  logic vin_q, din_q;
  logic [SlotW:0] cnt_q;
  scan_t tok_q;
  scan_t chain [NumBuffers+1];
  scan_t scan_in [NumBuffers];
  scan_t stage_q [NumBuffers];
  logic [NumBuffers-1:0] cval;
  logic [7:0] crefs [NumBuffers];
  logic [RankW-1:0] crank [NumBuffers];
  cmd_t cmd;
  logic out_v_q;
  logic [4:0] o_slot_q;
  logic [2:0] o_st_q;
  logic o_dv_q;
  logic [7:0] o_rc_q;
  logic [4:0] r_slot;
  logic [2:0] r_st;
  logic r_dv;
  logic [7:0] r_rc;

  // The token is held in a stage register behind every cell; cell k sees it once it has
  // passed the stage registers of cells 0 to k-1, and the last stage carries the final verdict.
  assign chain[0] = '0;
  for (genvar k = 0; k < NumBuffers; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign scan_in[k] = chain[0];
    end else begin : g_link
      assign scan_in[k] = stage_q[k-1];
    end
    bbc_cell u_cell (
      .clk_i, .rst_ni,
      .idx_i(SlotW'(k)), .rank_rst_i(RankW'(k)),
      .device_i(dev_q), .sector_i(tag_q),
      .scan_i(scan_in[k]), .scan_o(chain[k+1]),
      .cmd_i(cmd), .valid_o(cval[k]), .refs_o(crefs[k]), .rank_o(crank[k])
    );
    always_ff @(posedge clk_i) stage_q[k] <= chain[k+1];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_valid_i) state_d = StMul;
      StMul: state_d = (mode_q == ModeGet) ? StScan : StApply;
      StScan: if (cnt_q == (SlotW+1)'(NumBuffers)) state_d = StApply;
      StApply: state_d = StOut;
      StOut: if (!out_v_q) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  assign in_ready_o = (state_q == StIdle);

  // Command and result formed in the apply cycle.
  always_comb begin
    cmd = '0;
    cmd.device = dev_q;
    cmd.sector = tag_q;
    cmd.slot = slot_q;
    cmd.valid = vin_q;
    cmd.dirty = din_q;
    cmd.rank = crank[slot_q];
    r_slot = '0; r_st = StatusDone; r_dv = 1'b0; r_rc = '0;
    if (state_q == StApply) begin
      unique case (mode_q)
        ModeGet: begin
          if (tok_q.hit) begin
            cmd.slot = tok_q.hit_slot;
            r_slot = tok_q.hit_slot;
            r_dv = cval[tok_q.hit_slot];
            if (crefs[tok_q.hit_slot] == 8'hFF) begin
              r_st = StatusOverflow; r_rc = 8'hFF;
            end else begin
              cmd.hit_inc = 1'b1;
              r_rc = crefs[tok_q.hit_slot] + 8'd1;
            end
          end else if (tok_q.free) begin
            cmd.slot = tok_q.free_slot;
            cmd.recycle = 1'b1;
            r_slot = tok_q.free_slot; r_st = StatusRecycled; r_rc = 8'd1;
          end else begin
            r_st = StatusNoFree;
          end
        end
        ModeRelease: begin
          r_slot = slot_q;
          r_dv = cval[slot_q];
          if (crefs[slot_q] == 8'd0) begin
            r_st = StatusBadRelease;
          end else begin
            cmd.rel_dec = 1'b1;
            cmd.to_mru = (crefs[slot_q] == 8'd1);
            r_rc = crefs[slot_q] - 8'd1;
          end
        end
        ModeFlags: begin
          cmd.set_flags = 1'b1;
          r_slot = slot_q; r_dv = vin_q; r_rc = crefs[slot_q];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      spb_q <= 5'd1;
      cnt_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) spb_q <= cfg_wdata_i;
      cnt_q <= (state_q == StScan) ? cnt_q + 1'b1 : '0;
      if (state_q == StApply) out_v_q <= 1'b1;
      else if (out_ready_i) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      mode_q <= mode_i; dev_q <= device_i; blk_q <= block_in_fs_i;
      base_q <= partition_base_i; slot_q <= slot_i;
      vin_q <= valid_in_i; din_q <= dirty_in_i;
    end
    if (state_q == StMul) tag_q <= base_q + 32'(blk_q * {27'd0, spb_q});
    if (state_q == StScan) tok_q <= stage_q[NumBuffers-1];
    if (state_q == StApply) begin
      o_slot_q <= r_slot; o_st_q <= r_st; o_dv_q <= r_dv; o_rc_q <= r_rc;
    end
  end

  assign out_valid_o = out_v_q;
  assign slot_out_o = o_slot_q;
  assign status_o = o_st_q;
  assign data_valid_o = o_dv_q;
  assign ref_count_o = o_rc_q;

  a_one_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("item accepted while result pending");
  a_scan_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StScan |-> cnt_q <= (SlotW+1)'(NumBuffers)) else $error("scan overrun");
  a_apply_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StApply |=> out_valid_o) else $error("result lost");
endmodule
`default_nettype wire

// ===== tb/sv/block_buffer_cache_lru_chk.sv =====
// Checker for the buffer cache block: predicts each result and compares it.
`timescale 1ns / 1ps
module block_buffer_cache_lru_chk
  import bbc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  device_i,
  input  logic [31:0] block_in_fs_i,
  input  logic [31:0] partition_base_i,
  input  logic [4:0]  slot_i,
  input  logic        valid_in_i,
  input  logic        dirty_in_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [4:0]  slot_out_i,
  input  logic [2:0]  status_i,
  input  logic        data_valid_i,
  input  logic [7:0]  ref_count_i,
  output int          fail_count_o,
  output int          pending_o
);
  typedef struct packed {
    logic [4:0] slot;
    logic [2:0] status;
    logic       data_valid;
    logic [7:0] refs;
  } cache_result_t;

  logic [4:0]  spb_q;
  logic [7:0]  tag_dev[NumBuffers];
  logic [31:0] tag_sector[NumBuffers];
  logic [7:0]  refs_q[NumBuffers];
  logic        valid_q[NumBuffers];
  logic        dirty_q[NumBuffers];
  logic        used_q[NumBuffers];
  int          rank_q[NumBuffers];
  cache_result_t expected_q[$];

  function automatic cache_result_t mk(logic [4:0] s, logic [2:0] st, logic dv,
                                       logic [7:0] r);
    cache_result_t res;
    res.slot = s;
    res.status = st;
    res.data_valid = dv;
    res.refs = r;
    return res;
  endfunction

  // Applies one request to the shadow cache state and returns its result.
  function automatic cache_result_t cache_lookup(logic [1:0] m, logic [7:0] dv,
                                                 logic [31:0] blk, logic [31:0] base,
                                                 logic [4:0] sl, logic vi, logic di);
    logic [31:0] tag;
    int pick;
    int best;
    int r;
    pick = -1;
    best = -1;
    if (m == ModeGet) begin
      tag = base + blk * {27'd0, spb_q};
      for (int i = 0; i < NumBuffers; i++) begin
        if (used_q[i] && tag_dev[i] == dv && tag_sector[i] == tag) begin
          if (refs_q[i] == 8'hff) return mk(i[4:0], StatusOverflow, valid_q[i], 8'hff);
          refs_q[i] = refs_q[i] + 8'd1;
          return mk(i[4:0], StatusDone, valid_q[i], refs_q[i]);
        end
      end
      for (int i = 0; i < NumBuffers; i++) begin
        if (refs_q[i] == 0 && !dirty_q[i] && rank_q[i] > best) begin
          best = rank_q[i];
          pick = i;
        end
      end
      if (pick < 0) return mk(5'd0, StatusNoFree, 1'b0, 8'd0);
      tag_dev[pick] = dv;
      tag_sector[pick] = tag;
      valid_q[pick] = 1'b0;
      dirty_q[pick] = 1'b0;
      used_q[pick] = 1'b1;
      refs_q[pick] = 8'd1;
      return mk(pick[4:0], StatusRecycled, 1'b0, 8'd1);
    end else if (m == ModeRelease) begin
      if (refs_q[sl] == 0) return mk(sl, StatusBadRelease, valid_q[sl], 8'd0);
      refs_q[sl] = refs_q[sl] - 8'd1;
      if (refs_q[sl] == 0) begin
        r = rank_q[sl];
        for (int i = 0; i < NumBuffers; i++) if (rank_q[i] < r) rank_q[i]++;
        rank_q[sl] = 0;
      end
      return mk(sl, StatusDone, valid_q[sl], refs_q[sl]);
    end else if (m == ModeFlags) begin
      valid_q[sl] = vi;
      dirty_q[sl] = di;
      return mk(sl, StatusDone, valid_q[sl], refs_q[sl]);
    end
    return mk(5'd0, StatusDone, 1'b0, 8'd0);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cache_result_t exp_r;
    if (!rst_ni) begin
      spb_q = 5'd1;
      for (int i = 0; i < NumBuffers; i++) begin
        tag_dev[i] = '0;
        tag_sector[i] = '0;
        refs_q[i] = '0;
        valid_q[i] = 1'b0;
        dirty_q[i] = 1'b0;
        used_q[i] = 1'b0;
        rank_q[i] = i;
      end
      expected_q.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) spb_q = cfg_wdata_i;
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result with nothing expected: slot %0d status %0d dv %0d refs %0d",
                   $time, slot_out_i, status_i, data_valid_i, ref_count_i);
          fail_count_o++;
        end else begin
          exp_r = expected_q.pop_front();
          if (exp_r.slot !== slot_out_i) begin
            $display("%0t: slot_out expected %0d actual %0d", $time, exp_r.slot, slot_out_i);
            fail_count_o++;
          end
          if (exp_r.status !== status_i) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_r.status, status_i);
            fail_count_o++;
          end
          if (exp_r.data_valid !== data_valid_i) begin
            $display("%0t: data_valid expected %0d actual %0d", $time, exp_r.data_valid,
                     data_valid_i);
            fail_count_o++;
          end
          if (exp_r.refs !== ref_count_i) begin
            $display("%0t: ref_count expected %0d actual %0d", $time, exp_r.refs,
                     ref_count_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i)
        expected_q.push_back(cache_lookup(mode_i, device_i, block_in_fs_i,
                                          partition_base_i, slot_i, valid_in_i, dirty_in_i));
    end
    pending_o = expected_q.size();
  end
endmodule

// ===== tb/sv/block_buffer_cache_lru_tb.sv =====
// Top of the buffer cache testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module block_buffer_cache_lru_tb;
  import bbc_pkg::*;

  localparam logic [1:0] ModeUnused = 2'd3;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [4:0]  cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  mode_i;
  logic [7:0]  device_i;
  logic [31:0] block_in_fs_i;
  logic [31:0] partition_base_i;
  logic [4:0]  slot_i;
  logic        valid_in_i;
  logic        dirty_in_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [4:0]  slot_out_o;
  logic [2:0]  status_o;
  logic        data_valid_o;
  logic [7:0]  ref_count_o;
  int          fail_count;
  int          pending;
  int          send_idle_pct;
  int          recv_idle_pct;
  logic        hold_start;
  int          hold_left;

  block_buffer_cache_lru dut (.*);

  block_buffer_cache_lru_chk u_chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o), .mode_i, .device_i, .block_in_fs_i,
    .partition_base_i, .slot_i, .valid_in_i, .dirty_in_i,
    .out_valid_i(out_valid_o), .out_ready_i, .slot_out_i(slot_out_o),
    .status_i(status_o), .data_valid_i(data_valid_o), .ref_count_i(ref_count_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // The receiver counts out a long hold-off on its own when asked to.
  always @(posedge clk_i) begin
    if (hold_start) begin
      hold_left <= 400;
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic send_req(input logic [1:0] m, input logic [7:0] dv, input logic [31:0] blk,
                          input logic [31:0] base, input logic [4:0] sl, input logic vi,
                          input logic di);
    in_valid_i <= 1'b1;
    mode_i <= m;
    device_i <= dv;
    block_in_fs_i <= blk;
    partition_base_i <= base;
    slot_i <= sl;
    valid_in_i <= vi;
    dirty_in_i <= di;
    do @(posedge clk_i); while (!in_ready_o);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  // Waits until every result has been taken, then lets the block settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_spb(input logic [4:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly a small pool of tags so that hits, releases and full caches all happen.
  task automatic random_req();
    int pick;
    logic [7:0] dv;
    logic [31:0] blk;
    logic [31:0] base;
    pick = $urandom_range(99);
    if ($urandom_range(99) < 15) begin
      dv = 8'($urandom);
      blk = $urandom;
      base = $urandom;
    end else begin
      dv = 8'($urandom_range(0, 3));
      blk = $urandom_range(0, 20);
      base = ($urandom_range(1) != 0) ? 32'd100 : 32'd0;
    end
    if (pick < 55) send_req(ModeGet, dv, blk, base, '0, 1'b0, 1'b0);
    else if (pick < 85)
      send_req(ModeRelease, dv, blk, base, 5'($urandom_range(31)), 1'b0, 1'b0);
    else if (pick < 97)
      send_req(ModeFlags, dv, blk, base, 5'($urandom_range(31)), 1'($urandom_range(1)),
               ($urandom_range(3) == 0));
    else send_req(ModeUnused, dv, blk, base, 5'($urandom), 1'($urandom_range(1)),
                  1'($urandom_range(1)));
  endtask

  task automatic random_phase(input int n, input int s_pct, input int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int k = 0; k < n; k++) begin
      if (k == n / 2) hold_start <= 1'b1;
      random_req();
      hold_start <= 1'b0;
      // A run of items with no idling on the sender side.
      if (k == n / 4) send_idle_pct = 0;
      if (k == n / 3) send_idle_pct = s_pct;
    end
    drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    mode_i = '0;
    device_i = '0;
    block_in_fs_i = '0;
    partition_base_i = '0;
    slot_i = '0;
    valid_in_i = 1'b0;
    dirty_in_i = 1'b0;
    out_ready_i = 1'b0;
    hold_start = 1'b0;
    hold_left = 0;
    send_idle_pct = 23;
    recv_idle_pct = 50;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_spb(5'd16);
    // Drive one tag's reference count up to its limit and past it.
    for (int k = 0; k < 257; k++) send_req(ModeGet, 8'haa, 32'd1, 32'd0, '0, 1'b0, 1'b0);
    // Directed cases: field extremes, wrapping tags, hits, flags and bad releases.
    send_req(ModeGet, 8'hff, 32'hffff_ffff, 32'hffff_ffff, '0, 1'b0, 1'b0);
    send_req(ModeGet, 8'hff, 32'hffff_ffff, 32'hffff_ffff, '0, 1'b0, 1'b0);
    send_req(ModeGet, 8'h00, 32'h0000_0000, 32'h0000_0000, '0, 1'b0, 1'b0);
    send_req(ModeGet, 8'h00, 32'h1000_0000, 32'h0000_0000, '0, 1'b0, 1'b0);
    send_req(ModeFlags, '0, '0, '0, 5'd30, 1'b1, 1'b0);
    send_req(ModeGet, 8'hff, 32'hffff_ffff, 32'hffff_ffff, '0, 1'b0, 1'b0);
    send_req(ModeRelease, '0, '0, '0, 5'd30, 1'b0, 1'b0);
    send_req(ModeRelease, '0, '0, '0, 5'd30, 1'b0, 1'b0);
    send_req(ModeRelease, '0, '0, '0, 5'd30, 1'b0, 1'b0);
    send_req(ModeRelease, '0, '0, '0, 5'd30, 1'b0, 1'b0);
    send_req(ModeRelease, '0, '0, '0, 5'd0, 1'b0, 1'b0);
    send_req(ModeFlags, '0, '0, '0, 5'd0, 1'b1, 1'b1);
    send_req(ModeFlags, '0, '0, '0, 5'd31, 1'b1, 1'b1);
    send_req(ModeRelease, '0, '0, '0, 5'd31, 1'b0, 1'b0);
    send_req(ModeGet, 8'haa, 32'd1, 32'd0, '0, 1'b0, 1'b0);
    send_req(ModeUnused, 8'hff, 32'hffff_ffff, 32'hffff_ffff, 5'd31, 1'b1, 1'b1);
    send_req(ModeFlags, '0, '0, '0, 5'd0, 1'b0, 1'b0);
    drain();
    write_spb(5'd0);
    send_req(ModeGet, 8'h12, 32'hdead_beef, 32'h0000_0040, '0, 1'b0, 1'b0);
    send_req(ModeGet, 8'h12, 32'h0000_0001, 32'h0000_0040, '0, 1'b0, 1'b0);
    drain();

    random_phase(210, 23, 50);
    write_spb(5'd31);
    random_phase(210, 50, 23);
    write_spb(5'd1);
    random_phase(210, 0, 0);

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

// ===== files.f =====
hw/rtl/bbc_pkg.sv
hw/rtl/bbc_cell.sv
hw/rtl/block_buffer_cache_lru.sv
tb/sv/block_buffer_cache_lru_chk.sv
tb/sv/block_buffer_cache_lru_tb.sv
